// File: src/base64_stream_codec_core_assert.svh
// Assertion helpers shared by the codec RTL.
`ifndef BASE64_STREAM_CODEC_CORE_ASSERT_SVH
`define BASE64_STREAM_CODEC_CORE_ASSERT_SVH

// A condition that must hold on every clock edge out of reset.
`define B64_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("base64 codec check failed");

// An implication checked in the same cycle.
`define B64_CHECK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 codec implication failed");

`endif

// File: src/b64_pkg.sv
package b64_pkg;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PADDED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd2;

  // Status codes reported on the final beat of a message.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LONE    = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Characters with a special role.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Produced-count limit (saturation value).
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Result buffer of the back end: up to four beats per item.
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = 2;
  localparam int RES_CNT_W = 3;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic        direction;
    logic        padded;
    logic [15:0] capacity;
  } b64_cfg_t;

  // One classified input item.
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] code;
    logic       code_ok;
    logic       is_eq;
    logic       last;
  } b64_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } b64_qstat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    logic [1:0] status;
  } b64_res_t;

  // Six-bit code to Base64 character.
  function automatic logic [7:0] code_to_char(input logic [5:0] c);
    logic [7:0] r;
    if (c < 6'd26) begin
      r = 8'd65 + {2'b00, c};
    end else if (c < 6'd52) begin
      r = 8'd71 + {2'b00, c};
    end else if (c < 6'd62) begin
      r = {2'b00, c} - 8'd4;
    end else if (c == 6'd62) begin
      r = CH_PLUS;
    end else begin
      r = CH_SLASH;
    end
    return r;
  endfunction

  // Character to {ok, code}; code is zero for a character outside the alphabet.
  function automatic logic [6:0] char_to_code(input logic [7:0] ch);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      t = ch - 8'd65;
      r = {1'b1, t[5:0]};
    end else if (ch >= 8'd97 && ch <= 8'd122) begin
      t = ch - 8'd71;
      r = {1'b1, t[5:0]};
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      t = ch + 8'd4;
      r = {1'b1, t[5:0]};
    end else if (ch == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (ch == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: src/b64_front.sv
module b64_front import b64_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  input  b64_qstat_t qstat,
  output logic       push,
  output b64_item_t  push_item
);

  logic [6:0] cls;

  // Accept a beat whenever the queue has room.
  assign s_axis_tready = !qstat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Classify the byte as a Base64 character so the back end sees a ready code.
  assign cls = char_to_code(s_axis_tdata);

  always_comb begin
    push_item.data    = s_axis_tdata;
    push_item.code    = cls[5:0];
    push_item.code_ok = cls[6];
    push_item.is_eq   = (s_axis_tdata == CH_EQ);
    push_item.last    = s_axis_tlast;
  end

endmodule

// File: src/b64_queue.sv
module b64_queue import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  b64_item_t  push_item,
  input  logic       pop,
  output b64_item_t  head,
  output b64_qstat_t qstat
);

  b64_item_t       entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == (Q_AW+1)'(Q_DEPTH));

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: src/b64_back.sv
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  b64_cfg_t   cfg,
  input  logic       clr,
  input  b64_item_t  head,
  input  b64_qstat_t qstat,
  output logic       pop,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [7:0] m_axis_tuser,   // [0] data_valid, [2:1] status, [7:3] zero
  output logic       m_axis_tlast
);

  // Message state.
  logic [1:0]  gp;
  logic [5:0]  carry;
  logic [15:0] produced;
  logic        invalid;
  logic [1:0]  pad_cnt;

  // Result buffer.
  b64_res_t             res_buf [MAX_RES];
  logic [RES_CNT_W-1:0] res_cnt;
  logic [RES_IDX_W-1:0] res_idx;

  // Next values.
  logic [1:0]           gp_next;
  logic [5:0]           carry_next;
  logic [15:0]          produced_next;
  logic                 invalid_next;
  logic [1:0]           pad_cnt_next;
  b64_res_t             res_next [MAX_RES];
  logic [RES_CNT_W-1:0] res_cnt_next;

  logic take;
  logic at_end;
  logic can_load;

  // Work out every beat that the head item causes, and the state it leaves.
  always_comb begin
    logic [7:0]           dl [MAX_RES];
    logic [RES_CNT_W-1:0] n;
    logic [RES_CNT_W-1:0] nd;
    logic [16:0]          sum;
    logic [15:0]          cnt_new;
    logic [1:0]           st;
    logic [7:0]           b;
    logic                 is_pad;
    logic [1:0]           gp_a;
    logic [1:0]           pc_a;
    logic [1:0]           k;
    logic                 do_char;
    logic [2:0]           total;
    logic [1:0]           g;
    logic [5:0]           cr;
    logic [5:0]           cd;
    logic                 inv;

    for (int i = 0; i < MAX_RES; i++) begin
      dl[i] = 8'd0;
    end
    n       = '0;
    st      = ST_OK;
    b       = head.data;
    is_pad  = 1'b0;
    gp_a    = 2'd0;
    pc_a    = 2'd0;
    k       = 2'd0;
    do_char = 1'b0;
    total   = 3'd0;
    g       = gp;
    cr      = carry;
    cd      = 6'd0;
    inv     = invalid;

    gp_next      = gp;
    carry_next   = carry;
    invalid_next = invalid;
    pad_cnt_next = pad_cnt;

    if (!cfg.direction) begin
      // Encode: three bytes become four characters.
      case (gp)
        2'd1: begin
          dl[n[1:0]] = code_to_char({carry[1:0], b[7:4]});
          n = n + 1'b1;
          carry_next = {2'b00, b[3:0]};
          gp_next    = 2'd2;
        end
        2'd2: begin
          dl[n[1:0]] = code_to_char({carry[3:0], b[7:6]});
          n = n + 1'b1;
          dl[n[1:0]] = code_to_char(b[5:0]);
          n = n + 1'b1;
          carry_next = 6'd0;
          gp_next    = 2'd0;
        end
        default: begin
          dl[n[1:0]] = code_to_char(b[7:2]);
          n = n + 1'b1;
          carry_next = {4'b0000, b[1:0]};
          gp_next    = 2'd1;
        end
      endcase
      // Close a partial group on the final byte.
      if (head.last) begin
        if (gp_next == 2'd1) begin
          dl[n[1:0]] = code_to_char({carry_next[1:0], 4'b0000});
          n = n + 1'b1;
          if (cfg.padded) begin
            dl[n[1:0]] = CH_EQ;
            n = n + 1'b1;
            dl[n[1:0]] = CH_EQ;
            n = n + 1'b1;
          end
        end else if (gp_next == 2'd2) begin
          dl[n[1:0]] = code_to_char({carry_next[3:0], 2'b00});
          n = n + 1'b1;
          if (cfg.padded) begin
            dl[n[1:0]] = CH_EQ;
            n = n + 1'b1;
          end
        end
      end
    end else begin
      // Decode: a '=' in the third or fourth place is held as possible padding.
      is_pad = cfg.padded && head.is_eq && gp[1];
      if (is_pad) begin
        gp_a = gp + 2'd1;
        pc_a = pad_cnt + 2'd1;
        pad_cnt_next = pc_a;
        g = gp_a;
        // Held padding that ends a message off the group boundary is misplaced.
        if (head.last && pc_a != 2'd0 && gp_a != 2'd0) begin
          k   = pc_a;
          g   = gp_a - pc_a;
          inv = 1'b1;
          pad_cnt_next = 2'd0;
        end
      end else begin
        // Held '=' followed by more data is misplaced: decode it as code zero.
        k       = pad_cnt;
        g       = gp - pad_cnt;
        do_char = 1'b1;
        inv     = invalid || (pad_cnt != 2'd0) || !head.code_ok;
        pad_cnt_next = 2'd0;
      end
      total = {1'b0, k} + {2'b00, do_char};
      // Up to three decode steps: flushed padding first, then the character.
      for (int i = 0; i < 3; i++) begin
        if (3'(i) < total) begin
          cd = (3'(i) < {1'b0, k}) ? 6'd0 : head.code;
          case (g)
            2'd0: begin
              cr = cd;
            end
            2'd1: begin
              dl[n[1:0]] = {cr[5:0], cd[5:4]};
              n = n + 1'b1;
              cr = {2'b00, cd[3:0]};
            end
            2'd2: begin
              dl[n[1:0]] = {cr[3:0], cd[5:2]};
              n = n + 1'b1;
              cr = {4'b0000, cd[1:0]};
            end
            default: begin
              dl[n[1:0]] = {cr[1:0], cd};
              n = n + 1'b1;
              cr = 6'd0;
            end
          endcase
          g = g + 2'd1;
        end
      end
      gp_next      = g;
      carry_next   = cr;
      invalid_next = inv;
    end

    // Saturating count of data beats in the message.
    sum     = {1'b0, produced} + 17'(n);
    cnt_new = sum[16] ? CNT_MAX : sum[15:0];
    produced_next = cnt_new;

    // Final status.
    if (!cfg.direction) begin
      st = (cnt_new >= cfg.capacity) ? ST_OVER : ST_OK;
    end else if (gp_next == 2'd1) begin
      st = ST_LONE;
    end else if (cnt_new > cfg.capacity || cnt_new == CNT_MAX) begin
      st = ST_OVER;
    end else if (inv) begin
      st = ST_INVALID;
    end

    // A final item with no data still ends the message with a status beat.
    nd = n;
    if (head.last && n == '0) begin
      n = 3'd1;
    end
    for (int i = 0; i < MAX_RES; i++) begin
      res_next[i].data       = (3'(i) < nd) ? dl[i] : 8'd0;
      res_next[i].data_valid = (3'(i) < nd);
      res_next[i].last       = head.last && (3'(i) == n - 3'd1);
      res_next[i].status     = (head.last && (3'(i) == n - 3'd1)) ? st : ST_OK;
    end
    res_cnt_next = n;

    // The final item starts a new message.
    if (head.last) begin
      gp_next       = 2'd0;
      carry_next    = 6'd0;
      produced_next = 16'd0;
      invalid_next  = 1'b0;
      pad_cnt_next  = 2'd0;
    end
  end

  // Load the next item as the last buffered beat leaves.
  assign take     = m_axis_tvalid && m_axis_tready;
  assign at_end   = ({1'b0, res_idx} == res_cnt - 3'd1);
  assign can_load = (res_cnt == '0) || (take && at_end);
  assign pop      = qstat.valid && can_load;

  // Control and message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt  <= '0;
      res_idx  <= '0;
      gp       <= '0;
      carry    <= '0;
      produced <= '0;
      invalid  <= 1'b0;
      pad_cnt  <= '0;
    end else begin
      if (pop) begin
        res_cnt  <= res_cnt_next;
        res_idx  <= '0;
        gp       <= gp_next;
        carry    <= carry_next;
        produced <= produced_next;
        invalid  <= invalid_next;
        pad_cnt  <= pad_cnt_next;
      end else if (take) begin
        if (at_end) begin
          res_cnt <= '0;
        end else begin
          res_idx <= res_idx + 1'b1;
        end
      end
      // A direction or padding change abandons the message.
      if (clr) begin
        gp       <= '0;
        carry    <= '0;
        produced <= '0;
        invalid  <= 1'b0;
        pad_cnt  <= '0;
      end
    end
  end

  // Buffered beats.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_buf[i] <= res_next[i];
      end
    end
  end

  // Output beat.
  assign m_axis_tvalid = (res_cnt != '0);
  assign m_axis_tdata  = res_buf[res_idx].data;
  assign m_axis_tuser  = {5'b00000, res_buf[res_idx].status, res_buf[res_idx].data_valid};
  assign m_axis_tlast  = res_buf[res_idx].last;

endmodule

// File: src/base64_stream_codec_core.sv
// Streaming Base64 codec (alphabet A-Z a-z 0-9 + /). With direction 0 it takes
// data bytes and sends characters, adding '=' padding in padded mode; with
// direction 1 it takes characters and sends bytes, stripping padding that ends
// a message whose length is a multiple of four. tlast on the input ends a
// message; the output beat that carries tlast also carries the status in
// tuser[2:1] (0 ok, 1 lone final character, 2 over capacity, 3 invalid
// character), and a beat with tuser[0] low carries status only. Each input item
// occupies the result stage until the last output beat it causes is taken, and
// the next item loads as that beat leaves; encoding gives four characters per
// three bytes. A four-entry queue in front of the result stage keeps the input
// taking beats while the output is stalled, until the queue is full. Configuration
// is written through cfg_we/cfg_index/cfg_data while the codec is idle; writing
// direction or padded abandons a message in flight.
`include "base64_stream_codec_core_assert.svh"

module base64_stream_codec_core import b64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
  input  logic                  s_axis_tlast,   // in_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
  output logic [7:0]            m_axis_tuser,   // [0] data_valid, [2:1] status, [7:3] zero
  output logic                  m_axis_tlast,   // out_last
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  b64_cfg_t   cfg;
  logic       clr;
  logic       push;
  logic       pop;
  b64_item_t  push_item;
  b64_item_t  head;
  b64_qstat_t qstat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= 1'b0;
      cfg.padded    <= 1'b1;
      cfg.capacity  <= CNT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION: cfg.direction <= cfg_data[0];
        REG_PADDED:    cfg.padded    <= cfg_data[0];
        REG_CAPACITY:  cfg.capacity  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clr = cfg_we && (cfg_index == REG_DIRECTION || cfg_index == REG_PADDED);

  b64_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .qstat         (qstat),
    .push          (push),
    .push_item     (push_item)
  );

  b64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  b64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .clr           (clr),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A status-only beat always ends the message.
  `B64_CHECK_IMPL(a_status_only_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  // Only the final beat carries a nonzero status.
  `B64_CHECK_IMPL(a_status_on_last, m_axis_tvalid && m_axis_tuser[2:1] != ST_OK, m_axis_tlast)
  // A status-only beat carries a zero byte.
  `B64_CHECK_IMPL(a_status_only_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)

endmodule

// File: verif/base64_stream_codec_checker.sv
// Watches both streams and the register port of the codec, predicts the
// output beats of every accepted input beat and compares them in order.
module base64_stream_codec_checker import b64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_data,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_data,
  input  logic [7:0]            out_user,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // Mirror of the codec registers.
  logic        decode_mode;
  logic        pad_mode;
  logic [15:0] capacity;

  // Message state.
  logic [1:0]  grp_pos;
  logic [5:0]  carry;
  logic [15:0] produced;
  logic        saw_invalid;
  logic [1:0]  held_pads;

  b64_res_t expected_beats[$];
  b64_res_t step_beats[$];

  function automatic void clear_message();
    grp_pos     = 2'd0;
    carry       = 6'd0;
    produced    = 16'd0;
    saw_invalid = 1'b0;
    held_pads   = 2'd0;
  endfunction

  // Six-bit value to its alphabet character.
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s <= 6'd25) return 8'h41 + s;
    if (s <= 6'd51) return 8'h61 + (s - 6'd26);
    if (s <= 6'd61) return 8'h30 + (s - 6'd52);
    return (s == 6'd62) ? CH_PLUS : CH_SLASH;
  endfunction

  // Alphabet character to its six-bit value; false (and zero) outside it.
  function automatic logic char_sextet(input logic [7:0] ch, output logic [5:0] s);
    logic [7:0] t;
    logic       ok;
    t  = 8'd0;
    ok = 1'b1;
    if (ch >= 8'h41 && ch <= 8'h5A) t = ch - 8'h41;
    else if (ch >= 8'h61 && ch <= 8'h7A) t = ch - 8'h61 + 8'd26;
    else if (ch >= 8'h30 && ch <= 8'h39) t = ch - 8'h30 + 8'd52;
    else if (ch == CH_PLUS) t = 8'd62;
    else if (ch == CH_SLASH) t = 8'd63;
    else ok = 1'b0;
    s = t[5:0];
    return ok;
  endfunction

  // One data beat; the produced count saturates.
  function automatic void put_beat(input logic [7:0] v);
    b64_res_t r;
    if (step_beats.size() >= MAX_RES) return;
    r.data       = v;
    r.data_valid = 1'b1;
    r.last       = 1'b0;
    r.status     = ST_OK;
    step_beats.push_back(r);
    if (produced != CNT_MAX) produced++;
  endfunction

  // Feed one six-bit value into the decode group.
  function automatic void take_sextet(input logic [5:0] s);
    case (grp_pos)
      2'd0: carry = s;
      2'd1: begin
        put_beat({carry, s[5:4]});
        carry = {2'b00, s[3:0]};
      end
      2'd2: begin
        put_beat({carry[3:0], s[5:2]});
        carry = {4'b0000, s[1:0]};
      end
      default: begin
        put_beat({carry[1:0], s});
        carry = 6'd0;
      end
    endcase
    grp_pos = grp_pos + 2'd1;
  endfunction

  // Held '=' characters that turned out not to be padding decode as invalid zeros.
  function automatic void flush_held_pads();
    logic [1:0] k;
    k         = held_pads;
    grp_pos   = grp_pos - k;
    held_pads = 2'd0;
    repeat (k) begin
      saw_invalid = 1'b1;
      take_sextet(6'd0);
    end
  endfunction

  task automatic predict_beats(input logic [7:0] b, input logic fin);
    logic [5:0] s;
    logic [1:0] st;
    b64_res_t   r;
    st = ST_OK;
    step_beats.delete();
    if (!decode_mode) begin
      // Encode: three bytes give four characters.
      case (grp_pos)
        2'd1: begin
          put_beat(sextet_char({carry[1:0], b[7:4]}));
          carry   = {2'b00, b[3:0]};
          grp_pos = 2'd2;
        end
        2'd2: begin
          put_beat(sextet_char({carry[3:0], b[7:6]}));
          put_beat(sextet_char(b[5:0]));
          carry   = 6'd0;
          grp_pos = 2'd0;
        end
        default: begin
          put_beat(sextet_char(b[7:2]));
          carry   = {4'b0000, b[1:0]};
          grp_pos = 2'd1;
        end
      endcase
      if (fin) begin
        if (grp_pos == 2'd1) begin
          put_beat(sextet_char({carry[1:0], 4'b0000}));
          if (pad_mode) begin
            put_beat(CH_EQ);
            put_beat(CH_EQ);
          end
        end else if (grp_pos == 2'd2) begin
          put_beat(sextet_char({carry[3:0], 2'b00}));
          if (pad_mode) put_beat(CH_EQ);
        end
        st = (produced >= capacity) ? ST_OVER : ST_OK;
      end
    end else begin
      // Decode: '=' in the back half of a group is held as possible padding.
      if (pad_mode && b == CH_EQ && grp_pos >= 2'd2) begin
        held_pads = held_pads + 2'd1;
        grp_pos   = grp_pos + 2'd1;
      end else begin
        if (held_pads != 2'd0) flush_held_pads();
        if (!char_sextet(b, s)) saw_invalid = 1'b1;
        take_sextet(s);
      end
      if (fin) begin
        if (held_pads != 2'd0 && grp_pos != 2'd0) flush_held_pads();
        if (grp_pos == 2'd1) st = ST_LONE;
        else if (produced > capacity || produced == CNT_MAX) st = ST_OVER;
        else if (saw_invalid) st = ST_INVALID;
      end
    end
    // The final beat of a message carries the status; a status-only beat if no data.
    if (fin) begin
      if (step_beats.size() == 0) begin
        r = '0;
        step_beats.push_back(r);
      end
      r        = step_beats.pop_back();
      r.last   = 1'b1;
      r.status = st;
      step_beats.push_back(r);
      clear_message();
    end
    while (step_beats.size() != 0) expected_beats.push_back(step_beats.pop_front());
  endtask

  always @(posedge clk) begin
    b64_res_t want;
    if (rst) begin
      decode_mode = 1'b0;
      pad_mode    = 1'b1;
      capacity    = 16'hFFFF;
      clear_message();
      expected_beats.delete();
      fail_count  = 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_DIRECTION: begin
            decode_mode = cfg_data[0];
            clear_message();
          end
          REG_PADDED: begin
            pad_mode = cfg_data[0];
            clear_message();
          end
          REG_CAPACITY: capacity = cfg_data;
          default: ;
        endcase
      end
      // Output beats are compared before the input beat of this edge is predicted.
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: tdata %h tuser %h tlast %b", out_data, out_user, out_last);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_data);
            fail_count++;
          end
          if (out_user[0] !== want.data_valid) begin
            $error("data_valid: expected %b, actual %b", want.data_valid, out_user[0]);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last);
            fail_count++;
          end
          if (out_user[2:1] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_user[2:1]);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_beats(in_data, in_last);
    end
    pending = expected_beats.size();
  end

endmodule

// File: verif/base64_stream_codec_core_tb.sv
module base64_stream_codec_core_tb;
  import b64_pkg::*;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 3000;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'd0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic [7:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int   fail_count;
  int   pending;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   items_sent    = 0;
  logic hold_req      = 1'b0;
  logic cur_dir       = DIR_ENCODE;

  base64_stream_codec_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  base64_stream_codec_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one beat after a random gap and wait until it is taken.
  task automatic offer_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected beat and for any silent work to finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes; direction and padded only when all_regs is set.
  task automatic set_codec(input logic all_regs, input logic dir, input logic pad,
                           input logic [15:0] cap);
    logic [15:0] v;
    cfg_we <= 1'b1;
    if (all_regs) begin
      v = 16'($urandom);
      v[0] = dir;
      cfg_index <= REG_DIRECTION;
      cfg_data  <= v;
      @(negedge clk);
      v = 16'($urandom);
      v[0] = pad;
      cfg_index <= REG_PADDED;
      cfg_data  <= v;
      @(negedge clk);
      cur_dir = dir;
    end
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] b64_char();
    case ($urandom_range(3))
      0:       return 8'(8'h41 + $urandom_range(25));
      1:       return 8'(8'h61 + $urandom_range(25));
      2:       return 8'(8'h30 + $urandom_range(9));
      default: return $urandom_range(1) ? CH_PLUS : CH_SLASH;
    endcase
  endfunction

  task automatic send_bytes(input int n, input logic ends);
    int i;
    for (i = 0; i < n; i++) offer_item(8'($urandom_range(255)), ends && (i == n - 1));
  endtask

  // Mostly well-formed text with optional padding; sometimes noise, a cut or no end.
  task automatic send_text(input int groups);
    logic [7:0] txt[$];
    int         i;
    int         cut;
    logic       ends;
    for (i = 0; i < 4 * groups; i++) txt.push_back(b64_char());
    case ($urandom_range(2))
      1: txt[txt.size() - 1] = CH_EQ;
      2: begin
        txt[txt.size() - 1] = CH_EQ;
        txt[txt.size() - 2] = CH_EQ;
      end
      default: ;
    endcase
    if ($urandom_range(5) == 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
    cut = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0;
    repeat (cut) void'(txt.pop_back());
    ends = ($urandom_range(15) != 0);
    for (i = 0; i < txt.size(); i++) offer_item(txt[i], ends && (i == txt.size() - 1));
  endtask

  function automatic logic [15:0] pick_capacity();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'($urandom_range(12, 1));
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_traffic(input int target);
    while (items_sent < target) begin
      if ($urandom_range(2) == 0) begin
        settle();
        set_codec($urandom_range(3) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  pick_capacity());
      end
      if (cur_dir == DIR_DECODE) send_text($urandom_range(2, 1));
      else send_bytes($urandom_range(7, 1), $urandom_range(9) != 0);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // A write to an index with no register must change nothing.
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'hFFFF;
    @(negedge clk);

    src_idle_pct  = 18;
    sink_idle_pct = 59;

    // Encode one, two and three bytes: double pad, single pad, none.
    set_codec(1'b1, DIR_ENCODE, 1'b1, 16'hFFFF);
    offer_item(8'h00, 1'b1);
    offer_item(8'hFF, 1'b0);
    offer_item(8'hFF, 1'b1);
    offer_item(8'h00, 1'b0);
    offer_item(8'h80, 1'b0);
    offer_item(8'hFF, 1'b1);

    // Unpadded encode that fills the capacity and leaves no room for a terminator.
    settle();
    set_codec(1'b1, DIR_ENCODE, 1'b0, 16'd2);
    offer_item(8'hFB, 1'b1);

    // Padded decode: good padding, padding in mid group, plus and slash,
    // padding final at a length that is not a multiple of four, a lone bad character.
    settle();
    set_codec(1'b1, DIR_DECODE, 1'b1, 16'hFFFF);
    offer_item("Q", 1'b0);
    offer_item("Q", 1'b0);
    offer_item(CH_EQ, 1'b0);
    offer_item(CH_EQ, 1'b1);
    offer_item("A", 1'b0);
    offer_item("B", 1'b0);
    offer_item(CH_EQ, 1'b0);
    offer_item("C", 1'b1);
    offer_item(CH_PLUS, 1'b0);
    offer_item(CH_SLASH, 1'b0);
    offer_item("9", 1'b0);
    offer_item("z", 1'b1);
    offer_item("Q", 1'b0);
    offer_item("Q", 1'b0);
    offer_item(CH_EQ, 1'b1);
    offer_item(8'hFF, 1'b1);

    // Unpadded decode with zero capacity: '=' is invalid, over capacity wins.
    settle();
    set_codec(1'b1, DIR_DECODE, 1'b0, 16'd0);
    offer_item("Q", 1'b0);
    offer_item(CH_EQ, 1'b1);

    random_traffic(items_sent + 26);

    settle();
    src_idle_pct  = 59;
    sink_idle_pct = 18;
    random_traffic(items_sent + 26);

    // No idling; the receiver holds off while a long encode keeps coming.
    settle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_codec(1'b1, DIR_ENCODE, 1'b1, 16'hFFFF);
    hold_req = 1'b1;
    send_bytes(12, 1'b1);
    random_traffic(items_sent + 26);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
